@@ src/hptff_pkg.sv @@
// Shared types and constants for the hashed page table fault filler.
// No dependencies; imported by hashed_page_table_fault_fill.
package hptff_pkg;

  localparam int unsigned TableGroups = 1024;
  localparam int unsigned GroupWays   = 8;
  localparam int unsigned GroupW      = $clog2(TableGroups);
  localparam int unsigned SlotW       = $clog2(GroupWays);
  localparam int unsigned PidW        = 4;
  localparam int unsigned AddrW       = 32;

  localparam logic [GroupW-1:0] HashMaskReset = GroupW'(TableGroups - 1);
  localparam logic [31:0]       EntryValid    = 32'h8000_0000;
  localparam logic [11:0]       LowFlags      = 12'h182;

  typedef enum logic {
    OP_SET_SPACE = 1'b0,
    OP_FAULT     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_SET         = 2'd0,
    ST_INSERTED    = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_HANDLED = 2'd3
  } status_e;

  typedef logic [GroupWays-1:0] way_mask_t;

endpackage

@@ src/hashed_page_table_fault_fill.sv @@
// Top level of the hashed page table fault filler: space table, group
// valid map memory, shared 33-bit adder and the sequencer around them.
// Depends on hptff_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: either a
//   set-space transaction that records a partition's base and size, or a
//   fault transaction that picks a group by hashing partition id and page
//   number and claims the first free slot of that group.
//   Output channel (out_valid_o / out_ready_i) returns one result per item
//   with a status, the group, the slot and the two entry words.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes hash_mask; it
//   is always ready.
//   A set-space item goes from accept straight to EMIT; a fault goes through
//   CHECK, then ADDR if it reaches the table, then EMIT, which loads the
//   output register. A new item is taken the cycle after the result is
//   registered. The single adder (bound check, then base plus page address)
//   and the registered group read are why a fault needs both CHECK and ADDR.
//   Reset clears the space table and sets the mask to all ones, then a
//   clearing pass walks the 1024 groups, one per cycle, during which
//   in_ready_o stays low.
//   When the receiver stalls the result holds in the output register and
//   the block waits before loading the next one.
module hashed_page_table_fault_fill (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [9:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [3:0]               guest_id_i,
  input  logic [31:0]              fault_address_i,
  input  logic                     page_fault_i,
  input  logic [31:0]              space_base_i,
  input  logic [31:0]              space_size_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output hptff_pkg::status_e       status_o,
  output logic [9:0]               group_index_o,
  output logic [2:0]               slot_index_o,
  output logic [31:0]              entry_high_o,
  output logic [31:0]              entry_low_o
);
  import hptff_pkg::*;

  localparam int unsigned NumPartitions = 2 ** PidW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ADDR,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [GroupW-1:0]   clr_q;
  logic [GroupW-1:0]   hash_mask_q;

  // space table
  logic [AddrW-1:0]    base_tab_q [NumPartitions];
  logic [AddrW-1:0]    size_tab_q [NumPartitions];

  // latched item
  logic                op_q;
  logic [PidW-1:0]     pid_q;
  logic [AddrW-1:0]    addr_q;
  logic                pf_q;
  logic [AddrW-1:0]    base_q;
  logic [AddrW-1:0]    size_q;
  logic [GroupW-1:0]   grp_q;

  // pending result
  status_e             res_status_q;
  logic [GroupW-1:0]   res_grp_q;
  logic [SlotW-1:0]    res_slot_q;
  logic [31:0]         res_hi_q;
  logic [31:0]         res_lo_q;

  logic                out_valid_q;
  status_e             status_q;
  logic [GroupW-1:0]   group_q;
  logic [SlotW-1:0]    slot_q;
  logic [31:0]         hi_q;
  logic [31:0]         lo_q;

  // group valid map
  way_mask_t           grp_mem [TableGroups];
  way_mask_t           rd_q;
  logic                mem_re;
  logic                mem_we;
  logic [GroupW-1:0]   mem_waddr;
  way_mask_t           mem_wdata;

  // shared adder
  logic [AddrW-1:0]    add_a;
  logic [AddrW-1:0]    add_b;
  logic                add_cin;
  logic [AddrW:0]      add_sum;

  logic                in_fire;
  logic                out_free;
  logic                free_found;
  logic [SlotW-1:0]    free_slot;
  logic [GroupW-1:0]   hash_grp;
  logic [31:0]         entry_hi;
  logic [AddrW-1:0]    vaddr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign vaddr    = {addr_q[AddrW-1:12], 12'h000};
  assign hash_grp = ({{(GroupW-PidW){1'b0}}, pid_q} ^ addr_q[12 +: GroupW]) & hash_mask_q;
  assign entry_hi = EntryValid | {21'd0, pid_q, 1'b0, addr_q[27:22]};

  // CHECK: addr - size (borrow tells addr < size); ADDR: base + page address
  always_comb begin
    if (state_q == S_CHECK) begin
      add_a   = addr_q;
      add_b   = ~size_q;
      add_cin = 1'b1;
    end else begin
      add_a   = base_q;
      add_b   = vaddr;
      add_cin = 1'b0;
    end
  end
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{AddrW{1'b0}}, add_cin};

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = GroupWays - 1; i >= 0; i--) begin
      if (!rd_q[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  assign mem_re = (state_q == S_CHECK);
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = grp_q;
    mem_wdata = rd_q;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_ADDR && free_found) begin
      mem_we               = 1'b1;
      mem_wdata[free_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grp_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= grp_mem[hash_grp];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mask_q <= HashMaskReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hash_mask_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPartitions; i++) begin
        base_tab_q[i] <= '0;
        size_tab_q[i] <= '0;
      end
    end else if (in_fire && operation_i == OP_SET_SPACE) begin
      base_tab_q[guest_id_i] <= space_base_i;
      size_tab_q[guest_id_i] <= space_size_i;
    end
  end

  // Payload latches carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      pid_q  <= guest_id_i;
      addr_q <= fault_address_i;
      pf_q   <= page_fault_i;
      base_q <= base_tab_q[guest_id_i];
      size_q <= size_tab_q[guest_id_i];
    end
    if (state_q == S_CHECK) begin
      grp_q <= hash_grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      res_status_q <= ST_NOT_HANDLED;
      res_grp_q    <= '0;
      res_slot_q   <= '0;
      res_hi_q     <= '0;
      res_lo_q     <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_NOT_HANDLED;
      group_q      <= '0;
      slot_q       <= '0;
      hi_q         <= '0;
      lo_q         <= '0;
    end else begin
      // EMIT reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == GroupW'(TableGroups - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            res_grp_q  <= '0;
            res_slot_q <= '0;
            res_hi_q   <= '0;
            res_lo_q   <= '0;
            if (operation_i == OP_SET_SPACE) begin
              res_status_q <= ST_SET;
              state_q      <= S_EMIT;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // carry out set means addr >= size, which also covers size zero
          if (!pf_q || add_sum[AddrW] || op_q == OP_SET_SPACE) begin
            res_status_q <= ST_NOT_HANDLED;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          res_grp_q <= grp_q;
          if (free_found) begin
            res_status_q <= ST_INSERTED;
            res_slot_q   <= free_slot;
            res_hi_q     <= entry_hi;
            res_lo_q     <= {add_sum[AddrW-1:12], LowFlags};
          end else begin
            res_status_q <= ST_FULL;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            group_q     <= res_grp_q;
            slot_q      <= res_slot_q;
            hi_q        <= res_hi_q;
            lo_q        <= res_lo_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign group_index_o = group_q;
  assign slot_index_o  = slot_q;
  assign entry_high_o  = hi_q;
  assign entry_low_o   = lo_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("item accepted while previous item in flight");

  a_inserted_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_INSERTED |-> entry_high_o[31] && entry_low_o[8:7] == 2'b11)
    else $error("inserted entry lacks valid or flag bits");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_INSERTED |-> slot_index_o == '0 && entry_high_o == '0 &&
    entry_low_o == '0)
    else $error("non-insert result carries entry fields");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("group map written while idle");

endmodule
